### rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// Complex FIR decimator package
// Shared types and constants for the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // Input item kinds, carried in tuser.
    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Coefficient table selectors.
    localparam logic STAGE_FIRST = 1'b0;
    localparam logic STAGE_FINAL = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FACTOR     = 2'd0;
    localparam logic [1:0] CFG_TWO_STAGE  = 2'd1;
    localparam logic [1:0] CFG_FIRST_TAPS = 2'd2;
    localparam logic [1:0] CFG_FINAL_TAPS = 2'd3;

    // Register widths and reset values.
    localparam int CFG_DATA_W   = 9;
    localparam int FACTOR_W     = 4;
    localparam int TAPCFG_W     = 9;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd4;
    localparam logic [FACTOR_W-1:0] FACTOR_MIN   = 4'd2;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 4'd8;

    // Sample and coefficient format.
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ROUND_BIAS = 16384;
    localparam int FRAC_BITS  = 15;
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LAUNCH = 4'b0010,
        S_FIR    = 4'b0100,
        S_MID    = 4'b1000
    } t_state;

    // Which coefficients and which history one filter pass uses.
    typedef enum logic [1:0] {
        SEL_FIRST_IN   = 2'd0,
        SEL_SECOND_IN  = 2'd1,
        SEL_SECOND_MID = 2'd2
    } t_fir_sel;

    // Commands from controller to datapath.
    typedef struct packed {
        logic     coef_we;
        logic     push_in;
        logic     clear;
        logic     fir_start;
        t_fir_sel sel;
        logic     push_mid;
        logic     out_load;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic fir_done;
        logic out_busy;
    } t_status;

endpackage

### rtl/core/cfd_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cfd_dp.sv
// ----------------------------------------------------------------------------
// Complex FIR decimator datapath
// Coefficient and history memories, the shared complex MAC pipeline,
// rounding with saturation, and the output word register.
// ----------------------------------------------------------------------------
module cfd_dp #(
    parameter int MAX_TAP_COUNT = 257
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cfd_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_TAP_COUNT+1)-1:0]     i_taps,
    input  logic                                   i_coef_stage,
    input  logic [8:0]                             i_coef_index,
    input  logic signed [cfd_pkg::SAMPLE_W-1:0]    i_coef_value,
    input  logic signed [cfd_pkg::SAMPLE_W-1:0]    i_sample_i,
    input  logic signed [cfd_pkg::SAMPLE_W-1:0]    i_sample_q,
    input  logic                                   i_out_ready,
    output cfd_pkg::t_status                       o_status,
    output logic                                   o_out_valid,
    output logic signed [cfd_pkg::SAMPLE_W-1:0]    o_out_i,
    output logic signed [cfd_pkg::SAMPLE_W-1:0]    o_out_q
);

    localparam int AW    = $clog2(MAX_TAP_COUNT);
    localparam int TW    = $clog2(MAX_TAP_COUNT + 1);
    localparam int ACC_W = cfd_pkg::PROD_W + TW;
    localparam int SW    = cfd_pkg::SAMPLE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAP_COUNT - 1);
    localparam logic [TW-1:0] FILL_MAX  = TW'(MAX_TAP_COUNT);

    // History pointers and fill counts; entries beyond the fill read as zero.
    logic [AW-1:0] r_in_wptr, r_mid_wptr;
    logic [TW-1:0] r_in_fill, r_mid_fill;

    // Tap sequencing.
    logic [TW-1:0]     r_k, r_left;
    logic [AW-1:0]     r_rd_ptr;
    cfd_pkg::t_fir_sel r_sel;

    // Pipeline flags and data.
    logic r_s1_v, r_s1_live, r_s1_last;
    logic r_s2_v, r_s2_last;
    logic r_rnd, r_done;
    logic signed [cfd_pkg::PROD_W-1:0] r_prod_i, r_prod_q;
    logic signed [ACC_W-1:0]           r_acc_i, r_acc_q;
    logic signed [SW-1:0]              r_res_i, r_res_q;

    // Output word register.
    logic                 r_out_v;
    logic signed [SW-1:0] r_out_i, r_out_q;

    // Memory ports.
    logic          coef_ok, c1_we, c2_we;
    logic [AW-1:0] coef_waddr;
    logic [SW-1:0] c1_rd, c2_rd;
    logic [2*SW-1:0] ih_rd, mh_rd;

    logic                 issue, live, last;
    logic [TW-1:0]        fill_sel;
    logic signed [SW-1:0] coef_sel, hist_i, hist_q;
    logic signed [SW-1:0] sat_i, sat_q;
    logic signed [cfd_pkg::PROD_W-1:0] mul_i, mul_q;

    // Coefficient writes beyond the table are dropped.
    assign coef_ok    = 32'(i_coef_index) < 32'(MAX_TAP_COUNT);
    assign coef_waddr = AW'(i_coef_index);
    assign c1_we = i_cmd.coef_we && coef_ok && (i_coef_stage == cfd_pkg::STAGE_FIRST);
    assign c2_we = i_cmd.coef_we && coef_ok && (i_coef_stage == cfd_pkg::STAGE_FINAL);

    cfd_ram #(.WIDTH(SW), .DEPTH(MAX_TAP_COUNT)) u_coef1 (
        .i_clk(i_clk), .i_we(c1_we), .i_waddr(coef_waddr), .i_wdata(i_coef_value),
        .i_raddr(r_k[AW-1:0]), .o_rdata(c1_rd)
    );

    cfd_ram #(.WIDTH(SW), .DEPTH(MAX_TAP_COUNT)) u_coef2 (
        .i_clk(i_clk), .i_we(c2_we), .i_waddr(coef_waddr), .i_wdata(i_coef_value),
        .i_raddr(r_k[AW-1:0]), .o_rdata(c2_rd)
    );

    cfd_ram #(.WIDTH(2*SW), .DEPTH(MAX_TAP_COUNT)) u_in_hist (
        .i_clk(i_clk), .i_we(i_cmd.push_in), .i_waddr(r_in_wptr),
        .i_wdata({i_sample_q, i_sample_i}), .i_raddr(r_rd_ptr), .o_rdata(ih_rd)
    );

    cfd_ram #(.WIDTH(2*SW), .DEPTH(MAX_TAP_COUNT)) u_mid_hist (
        .i_clk(i_clk), .i_we(i_cmd.push_mid), .i_waddr(r_mid_wptr),
        .i_wdata({r_res_q, r_res_i}), .i_raddr(r_rd_ptr), .o_rdata(mh_rd)
    );

    // History write pointers and fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_wptr  <= '0;
            r_mid_wptr <= '0;
            r_in_fill  <= '0;
            r_mid_fill <= '0;
        end else begin
            if (i_cmd.push_in) begin
                r_in_wptr <= (r_in_wptr == LAST_ADDR) ? '0 : r_in_wptr + 1'b1;
                if (i_cmd.clear) begin
                    r_in_fill <= TW'(1);
                end else if (r_in_fill != FILL_MAX) begin
                    r_in_fill <= r_in_fill + 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_mid_fill <= '0;
            end else if (i_cmd.push_mid) begin
                r_mid_wptr <= (r_mid_wptr == LAST_ADDR) ? '0 : r_mid_wptr + 1'b1;
                if (r_mid_fill != FILL_MAX) begin
                    r_mid_fill <= r_mid_fill + 1'b1;
                end
            end
        end
    end

    assign issue    = (r_left != '0);
    assign fill_sel = (r_sel == cfd_pkg::SEL_SECOND_MID) ? r_mid_fill : r_in_fill;
    assign live     = (r_k < fill_sel);
    assign last     = (r_left == TW'(1));

    // Tap sequencer: walks from the newest history entry backwards.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_k    <= '0;
            r_sel  <= cfd_pkg::SEL_SECOND_IN;
        end else if (i_cmd.fir_start) begin
            r_left <= i_taps;
            r_k    <= '0;
            r_sel  <= i_cmd.sel;
            if (i_cmd.sel == cfd_pkg::SEL_SECOND_MID) begin
                r_rd_ptr <= (r_mid_wptr == '0) ? LAST_ADDR : r_mid_wptr - 1'b1;
            end else begin
                r_rd_ptr <= (r_in_wptr == '0) ? LAST_ADDR : r_in_wptr - 1'b1;
            end
        end else if (issue) begin
            r_left   <= r_left - 1'b1;
            r_k      <= r_k + 1'b1;
            r_rd_ptr <= (r_rd_ptr == '0) ? LAST_ADDR : r_rd_ptr - 1'b1;
        end
    end

    // Operand selection from the registered memory reads.
    assign coef_sel = (r_sel == cfd_pkg::SEL_FIRST_IN) ? c1_rd : c2_rd;
    assign hist_i   = (r_sel == cfd_pkg::SEL_SECOND_MID) ? mh_rd[SW-1:0] : ih_rd[SW-1:0];
    assign hist_q   = (r_sel == cfd_pkg::SEL_SECOND_MID) ? mh_rd[2*SW-1:SW] : ih_rd[2*SW-1:SW];

    // Signed products of the current coefficient and history entry.
    assign mul_i = coef_sel * hist_i;
    assign mul_q = coef_sel * hist_q;

    // Multiply stage, then accumulate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_rnd  <= 1'b0;
        end else begin
            r_s1_v <= issue && !i_cmd.fir_start;
            r_s2_v <= r_s1_v;
            r_rnd  <= r_s2_v && r_s2_last;
        end
        r_s1_live <= live;
        r_s1_last <= last;
        r_s2_last <= r_s1_last;
        r_prod_i  <= r_s1_live ? mul_i : '0;
        r_prod_q  <= r_s1_live ? mul_q : '0;
        if (i_cmd.fir_start) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_s2_v) begin
            r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
        end
    end

    // Round to nearest with floor on the bias, then saturate.
    function automatic logic signed [SW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] y;
        logic signed [ACC_W:0] s;
        y = (ACC_W+1)'(acc) + (ACC_W+1)'(cfd_pkg::ROUND_BIAS);
        s = y >>> cfd_pkg::FRAC_BITS;
        if (s > (ACC_W+1)'(cfd_pkg::SAT_MAX)) begin
            return SW'(cfd_pkg::SAT_MAX);
        end else if (s < (ACC_W+1)'(cfd_pkg::SAT_MIN)) begin
            return SW'(cfd_pkg::SAT_MIN);
        end
        return s[SW-1:0];
    endfunction

    assign sat_i = round_sat(r_acc_i);
    assign sat_q = round_sat(r_acc_q);

    // Result register and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_rnd;
        end
        if (r_rnd) begin
            r_res_i <= sat_i;
            r_res_q <= sat_q;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_i <= r_res_i;
            r_out_q <= r_res_q;
        end
    end

    assign o_status.fir_done = r_done;
    assign o_status.out_busy = r_out_v && !i_out_ready;
    assign o_out_valid = r_out_v;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;

endmodule

### rtl/core/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// Complex FIR decimator controller
// Accepts words, tracks the decimation phases and sequences the filter passes.
// ----------------------------------------------------------------------------
module cfd_ctrl #(
    parameter int MAX_TAP_COUNT = 257
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    i_func,
    input  logic                                    i_start,
    input  logic [cfd_pkg::FACTOR_W-1:0]            i_factor,
    input  logic                                    i_two_stage,
    input  logic [cfd_pkg::TAPCFG_W-1:0]            i_first_taps,
    input  logic [cfd_pkg::TAPCFG_W-1:0]            i_final_taps,
    input  cfd_pkg::t_status                        i_status,
    output logic                                    o_ready,
    output cfd_pkg::t_cmd                           o_cmd,
    output logic [$clog2(MAX_TAP_COUNT+1)-1:0]      o_taps
);

    localparam int TW = $clog2(MAX_TAP_COUNT + 1);

    cfd_pkg::t_state   r_state, n_state;
    cfd_pkg::t_fir_sel r_sel, n_sel;
    logic [2:0]        r_in_phase, n_in_phase;
    logic              r_mid_phase, n_mid_phase;
    logic              r_emit2, n_emit2;

    logic                         accept;
    logic [cfd_pkg::FACTOR_W-1:0] factor;
    logic [2:0]                   ph;
    logic                         mph;

    // Clamp a configured tap count into the legal range.
    function automatic logic [TW-1:0] clamp_taps(input logic [cfd_pkg::TAPCFG_W-1:0] n);
        if (n == '0) begin
            return TW'(1);
        end else if (32'(n) > 32'(MAX_TAP_COUNT)) begin
            return TW'(MAX_TAP_COUNT);
        end
        return TW'(n);
    endfunction

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == cfd_pkg::S_IDLE);

    // Effective phases of this sample, after any start request.
    always_comb begin
        factor = i_factor;
        if (factor < cfd_pkg::FACTOR_MIN) begin
            factor = cfd_pkg::FACTOR_MIN;
        end else if (factor > cfd_pkg::FACTOR_MAX) begin
            factor = cfd_pkg::FACTOR_MAX;
        end
        ph  = i_start ? 3'd0 : r_in_phase;
        mph = i_start ? 1'b0 : r_mid_phase;
        if (!i_two_stage && ({1'b0, ph} >= factor)) begin
            ph = 3'd0;
        end
    end

    assign o_taps = (r_sel == cfd_pkg::SEL_FIRST_IN) ? clamp_taps(i_first_taps)
                                                     : clamp_taps(i_final_taps);

    // Next-state and command logic.
    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_in_phase  = r_in_phase;
        n_mid_phase = r_mid_phase;
        n_emit2     = r_emit2;
        o_cmd       = '0;
        o_cmd.sel   = r_sel;
        case (r_state)
            cfd_pkg::S_IDLE: begin
                if (accept && (i_func == cfd_pkg::FUNC_COEF)) begin
                    o_cmd.coef_we = 1'b1;
                end else if (accept) begin
                    o_cmd.push_in = 1'b1;
                    o_cmd.clear   = i_start;
                    n_mid_phase   = mph;
                    if (i_two_stage) begin
                        n_in_phase = {2'b00, ~ph[0]};
                        if (!ph[0]) begin
                            n_mid_phase = ~mph;
                            n_emit2     = !mph;
                            n_sel       = cfd_pkg::SEL_FIRST_IN;
                            n_state     = cfd_pkg::S_LAUNCH;
                        end
                    end else begin
                        n_in_phase = ({1'b0, ph} + 4'd1 == factor) ? 3'd0 : ph + 3'd1;
                        if (ph == 3'd0) begin
                            n_sel   = cfd_pkg::SEL_SECOND_IN;
                            n_state = cfd_pkg::S_LAUNCH;
                        end
                    end
                end
            end
            cfd_pkg::S_LAUNCH: begin
                o_cmd.fir_start = 1'b1;
                n_state         = cfd_pkg::S_FIR;
            end
            cfd_pkg::S_FIR: begin
                if (i_status.fir_done) begin
                    if (r_sel == cfd_pkg::SEL_FIRST_IN) begin
                        n_state = cfd_pkg::S_MID;
                    end else if (!i_status.out_busy) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = cfd_pkg::S_IDLE;
                    end else begin
                        n_state = cfd_pkg::S_MID;
                    end
                end
            end
            cfd_pkg::S_MID: begin
                // Either store the middle sample, or wait for the output register.
                if (r_sel == cfd_pkg::SEL_FIRST_IN) begin
                    o_cmd.push_mid = 1'b1;
                    if (r_emit2) begin
                        n_sel   = cfd_pkg::SEL_SECOND_MID;
                        n_state = cfd_pkg::S_LAUNCH;
                    end else begin
                        n_state = cfd_pkg::S_IDLE;
                    end
                end else if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cfd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfd_pkg::S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfd_pkg::S_IDLE;
            r_sel       <= cfd_pkg::SEL_SECOND_IN;
            r_in_phase  <= '0;
            r_mid_phase <= 1'b0;
            r_emit2     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_in_phase  <= n_in_phase;
            r_mid_phase <= n_mid_phase;
            r_emit2     <= n_emit2;
        end
    end

    // A filter pass only finishes while the controller waits for it.
    a_done_in_fir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.fir_done |-> (r_state == cfd_pkg::S_FIR))
        else $error("filter pass finished outside the wait state");

    // A launch is always followed by the wait for that pass.
    a_launch_then_fir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfd_pkg::S_LAUNCH) |=> (r_state == cfd_pkg::S_FIR))
        else $error("launch not followed by a filter pass");

    // The output register is never overwritten while a word is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_status.out_busy)
        else $error("output word overwritten");

endmodule

### rtl/core/complex_fir_decimator_top.sv
// ----------------------------------------------------------------------------
// Complex FIR decimator, top level
// Q15 complex FIR filter with decimation by 2..8 or a cascade of two
// decimate-by-2 stages, coefficients loaded through the input stream.
// ----------------------------------------------------------------------------
// A coefficient word, or a sample word that produces no filter pass, leaves the
// input ready for the next word. A sample that starts a filter pass over the
// clamped tap count of that pass holds the input until the pass has handed its
// word to the output register, or until a first-stage pass has stored its middle
// sample, since one shared complex multiply-accumulate unit reads one
// coefficient and one history entry per cycle from the memories; in two-stage
// mode a sample that also runs the final stage takes both passes back to back.
// A finished word waits in the output register, and the block stalls only if a
// further result is ready before that word has been taken. History is cleared
// through fill counts, so no clearing pass follows reset or a start request.
module complex_fir_decimator_top #(
    parameter int MAX_TAP_COUNT = 257
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_req[0], coef_stage[1], coef_index[10:2], coef_value[26:11],
    // sample_i[42:27], sample_q[58:43], zero fill[63:59]
    input  logic [63:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]  s_axis_tuser,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_i[15:0], out_q[31:16]
    output logic [31:0] m_axis_tdata
);

    localparam int TW = $clog2(MAX_TAP_COUNT + 1);

    logic [cfd_pkg::FACTOR_W-1:0] r_factor;
    logic                         r_two_stage;
    logic [cfd_pkg::TAPCFG_W-1:0] r_first_taps, r_final_taps;

    cfd_pkg::t_cmd    cmd;
    cfd_pkg::t_status status;
    logic [TW-1:0]    taps;
    logic signed [cfd_pkg::SAMPLE_W-1:0] out_i, out_q;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor     <= cfd_pkg::FACTOR_RESET;
            r_two_stage  <= 1'b0;
            r_first_taps <= cfd_pkg::TAPCFG_W'(1);
            r_final_taps <= cfd_pkg::TAPCFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cfd_pkg::CFG_FACTOR:     r_factor     <= i_cfg_wdata[cfd_pkg::FACTOR_W-1:0];
                cfd_pkg::CFG_TWO_STAGE:  r_two_stage  <= i_cfg_wdata[0];
                cfd_pkg::CFG_FIRST_TAPS: r_first_taps <= i_cfg_wdata;
                cfd_pkg::CFG_FINAL_TAPS: r_final_taps <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    cfd_ctrl #(.MAX_TAP_COUNT(MAX_TAP_COUNT)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_func       (s_axis_tuser[0]),
        .i_start      (s_axis_tdata[0]),
        .i_factor     (r_factor),
        .i_two_stage  (r_two_stage),
        .i_first_taps (r_first_taps),
        .i_final_taps (r_final_taps),
        .i_status     (status),
        .o_ready      (s_axis_tready),
        .o_cmd        (cmd),
        .o_taps       (taps)
    );

    cfd_dp #(.MAX_TAP_COUNT(MAX_TAP_COUNT)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_taps       (taps),
        .i_coef_stage (s_axis_tdata[1]),
        .i_coef_index (s_axis_tdata[10:2]),
        .i_coef_value (s_axis_tdata[26:11]),
        .i_sample_i   (s_axis_tdata[42:27]),
        .i_sample_q   (s_axis_tdata[58:43]),
        .i_out_ready  (m_axis_tready),
        .o_status     (status),
        .o_out_valid  (m_axis_tvalid),
        .o_out_i      (out_i),
        .o_out_q      (out_q)
    );

    assign m_axis_tdata = {out_q, out_i};

endmodule

### tb/cfd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex FIR decimator checker
// Watches the configuration port and both streams, keeps its own copy of the
// coefficient tables, histories and phases, predicts each filtered word and
// compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module cfd_checker #(
    parameter int TAPS = 257
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    output int          o_err_count,
    output int          o_pending
);

    typedef struct packed {
        logic signed [15:0] q;
        logic signed [15:0] i;
    } t_iq;

    // Shadow registers.
    logic [3:0] factor_reg = cfd_pkg::FACTOR_RESET;
    logic       two_stage_reg = 1'b0;
    logic [8:0] first_taps_reg = 9'd1;
    logic [8:0] final_taps_reg = 9'd1;

    // Shadow tables, histories and phases.
    int   first_coef [TAPS];
    int   final_coef [TAPS];
    int   in_hist_i  [TAPS];
    int   in_hist_q  [TAPS];
    int   mid_hist_i [TAPS];
    int   mid_hist_q [TAPS];
    int   in_phase = 0;
    bit   mid_phase = 1'b0;

    t_iq  filtered_q[$];

    assign o_pending = filtered_q.size();

    function automatic int clamp_taps(input logic [8:0] n);
        if (n < 1) return 1;
        if (n > TAPS) return TAPS;
        return int'(n);
    endfunction

    // Adds the rounding bias, floors by 2^15 and saturates to 16 bits.
    function automatic logic signed [15:0] round_sat(input longint acc);
        longint y;
        y = (acc + cfd_pkg::ROUND_BIAS) >>> cfd_pkg::FRAC_BITS;
        if (y > cfd_pkg::SAT_MAX) return 16'sd32767;
        if (y < cfd_pkg::SAT_MIN) return -16'sd32768;
        return y[15:0];
    endfunction

    // One complex filter pass: sel picks coefficient table and history.
    function automatic t_iq filter_pass(input cfd_pkg::t_fir_sel sel, input int taps);
        longint re, im;
        int     c, xi, xq;
        t_iq    r;
        re = 0;
        im = 0;
        for (int k = 0; k < taps; k++) begin
            c  = (sel == cfd_pkg::SEL_FIRST_IN) ? first_coef[k] : final_coef[k];
            xi = (sel == cfd_pkg::SEL_SECOND_MID) ? mid_hist_i[k] : in_hist_i[k];
            xq = (sel == cfd_pkg::SEL_SECOND_MID) ? mid_hist_q[k] : in_hist_q[k];
            re += longint'(c) * xi;
            im += longint'(c) * xq;
        end
        r.i = round_sat(re);
        r.q = round_sat(im);
        return r;
    endfunction

    task automatic apply_word(input logic [0:0] user, input logic [63:0] d);
        logic [8:0] idx;
        int         fac;
        t_iq        mid;
        idx = d[10:2];
        if (user[0] == cfd_pkg::FUNC_COEF) begin
            if (idx < TAPS) begin
                if (d[1] == cfd_pkg::STAGE_FINAL) final_coef[idx] = int'($signed(d[26:11]));
                else first_coef[idx] = int'($signed(d[26:11]));
            end
            return;
        end
        // A start request clears both histories and both phases.
        if (d[0]) begin
            for (int k = 0; k < TAPS; k++) begin
                in_hist_i[k] = 0; in_hist_q[k] = 0;
                mid_hist_i[k] = 0; mid_hist_q[k] = 0;
            end
            in_phase = 0;
            mid_phase = 1'b0;
        end
        for (int k = TAPS - 1; k > 0; k--) begin
            in_hist_i[k] = in_hist_i[k-1];
            in_hist_q[k] = in_hist_q[k-1];
        end
        in_hist_i[0] = int'($signed(d[42:27]));
        in_hist_q[0] = int'($signed(d[58:43]));
        if (two_stage_reg) begin
            if (in_phase[0] == 1'b0) begin
                mid = filter_pass(cfd_pkg::SEL_FIRST_IN, clamp_taps(first_taps_reg));
                for (int k = TAPS - 1; k > 0; k--) begin
                    mid_hist_i[k] = mid_hist_i[k-1];
                    mid_hist_q[k] = mid_hist_q[k-1];
                end
                mid_hist_i[0] = int'(mid.i);
                mid_hist_q[0] = int'(mid.q);
                if (!mid_phase)
                    filtered_q.push_back(filter_pass(cfd_pkg::SEL_SECOND_MID,
                                                     clamp_taps(final_taps_reg)));
                mid_phase = !mid_phase;
            end
            in_phase = (in_phase + 1) % 2;
        end else begin
            fac = int'(factor_reg);
            if (fac < cfd_pkg::FACTOR_MIN) fac = int'(cfd_pkg::FACTOR_MIN);
            if (fac > cfd_pkg::FACTOR_MAX) fac = int'(cfd_pkg::FACTOR_MAX);
            if (in_phase >= fac) in_phase = 0;
            if (in_phase == 0)
                filtered_q.push_back(filter_pass(cfd_pkg::SEL_SECOND_IN,
                                                 clamp_taps(final_taps_reg)));
            in_phase = (in_phase + 1) % fac;
        end
    endtask

    initial begin
        o_err_count = 0;
        for (int k = 0; k < TAPS; k++) begin
            first_coef[k] = 0; final_coef[k] = 0;
            in_hist_i[k] = 0; in_hist_q[k] = 0;
            mid_hist_i[k] = 0; mid_hist_q[k] = 0;
        end
    end

    // Compare output words first, then fold in what was written this edge.
    always @(posedge i_clk) begin
        t_iq got, want;
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            got = i_m_tdata;
            if (filtered_q.size() == 0) begin
                $display("%0t: output word with none expected, got i=%0d q=%0d",
                         $time, got.i, got.q);
                o_err_count++;
            end else begin
                want = filtered_q.pop_front();
                if (got.i !== want.i) begin
                    $display("%0t: out_i expected %0d, got %0d", $time, want.i, got.i);
                    o_err_count++;
                end
                if (got.q !== want.q) begin
                    $display("%0t: out_q expected %0d, got %0d", $time, want.q, got.q);
                    o_err_count++;
                end
            end
        end
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                cfd_pkg::CFG_FACTOR:     factor_reg = i_cfg_wdata[3:0];
                cfd_pkg::CFG_TWO_STAGE:  two_stage_reg = i_cfg_wdata[0];
                cfd_pkg::CFG_FIRST_TAPS: first_taps_reg = i_cfg_wdata;
                cfd_pkg::CFG_FINAL_TAPS: final_taps_reg = i_cfg_wdata;
                default: ;
            endcase
        end
        if (i_rst_n && i_s_tvalid && i_s_tready)
            apply_word(i_s_tuser, i_s_tdata);
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex FIR decimator testbench
// Loads both coefficient tables, runs a short directed sequence and then
// random phases under several register settings, with random idling on both
// streams; a checker module predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE = 700;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          err_count;
    int          pending;
    bit          quiet = 1'b0;
    bit          hold_off_req = 1'b0;

    complex_fir_decimator_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
    );

    cfd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_err_count(err_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random bursts of back-pressure, one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                n = 0;
                while (n < 3000) begin
                    @(negedge i_clk);
                    n++;
                end
                hold_off_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge i_clk);
            end
        end
    end

    // Offers one word, called at a falling edge, returns at a falling edge.
    task automatic send_word(input logic [0:0] user, input logic [63:0] d);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pack_word(input logic start, input logic stage,
                                              input logic [8:0] idx,
                                              input logic [15:0] coef,
                                              input logic [15:0] si,
                                              input logic [15:0] sq);
        return {5'b0, sq, si, coef, idx, stage, start};
    endfunction

    task automatic send_sample(input logic start, input logic [15:0] si,
                               input logic [15:0] sq);
        send_word(cfd_pkg::FUNC_SAMPLE,
                  pack_word(start, 1'($urandom), 9'($urandom), 16'($urandom), si, sq));
    endtask

    task automatic send_coef(input logic stage, input logic [8:0] idx,
                             input logic [15:0] val);
        send_word(cfd_pkg::FUNC_COEF,
                  pack_word(1'($urandom), stage, idx, val, 16'($urandom), 16'($urandom)));
    endtask

    // Waits until every expected word has come and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Factor and mode carry random upper bits, which the block must drop.
    task automatic configure(input logic [3:0] fac, input logic two,
                             input logic [8:0] t1, input logic [8:0] t2);
        write_reg(cfd_pkg::CFG_FACTOR, {5'($urandom_range(0, 31)), fac});
        write_reg(cfd_pkg::CFG_TWO_STAGE, {8'($urandom_range(0, 255)), two});
        write_reg(cfd_pkg::CFG_FIRST_TAPS, t1);
        write_reg(cfd_pkg::CFG_FINAL_TAPS, t2);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly samples with random content, some coefficient rewrites
    // (now and then out of range) and the occasional start request.
    task automatic random_items(input int n, input bit pause_midway);
        int r;
        for (int k = 0; k < n; k++) begin
            if (pause_midway && k == n / 2) begin
                s_tvalid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 10)
                send_coef(1'($urandom),
                          ($urandom_range(0, 7) == 0) ? 9'($urandom_range(257, 511))
                                                       : 9'($urandom_range(0, 256)),
                          rand_value());
            else
                send_sample(r > 94, rand_value(), rand_value());
        end
    endtask

    initial begin
        int fac, two, t1, t2;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill both tables so that no filter ever reads an unwritten tap.
        for (int k = 0; k < 257; k++) begin
            send_coef(cfd_pkg::STAGE_FIRST, 9'(k), 16'($urandom));
            send_coef(cfd_pkg::STAGE_FINAL, 9'(k), 16'($urandom));
        end

        // Directed: reset settings, extreme products and ignored writes.
        send_coef(cfd_pkg::STAGE_FINAL, 9'd0, 16'h8000);
        send_sample(1'b1, 16'h8000, 16'h7FFF);
        send_sample(1'b0, 16'h7FFF, 16'h8000);
        send_sample(1'b0, 16'h0000, 16'h0000);
        send_sample(1'b0, 16'hFFFF, 16'h0001);
        send_sample(1'b0, 16'h8000, 16'h8000);
        send_coef(cfd_pkg::STAGE_FINAL, 9'd300, 16'h1234);
        send_coef(cfd_pkg::STAGE_FIRST, 9'd511, 16'h7FFF);
        send_coef(cfd_pkg::STAGE_FINAL, 9'd0, 16'h7FFF);
        send_sample(1'b0, 16'h7FFF, 16'h7FFF);
        send_sample(1'b1, 16'h8000, 16'h0001);
        send_coef(cfd_pkg::STAGE_FINAL, 9'd256, 16'h4000);
        send_coef(cfd_pkg::STAGE_FIRST, 9'd256, 16'hC000);
        send_sample(1'b0, 16'h4000, 16'hC000);
        send_sample(1'b0, 16'h0001, 16'hFFFF);
        drain();

        // Extreme settings first; the long filters get few items.
        configure(4'd2, 1'b0, 9'd1, 9'd257);
        random_items(60, 1'b0);
        drain();
        configure(4'd8, 1'b0, 9'd1, 9'd1);
        random_items(150, 1'b1);
        drain();
        configure(4'd0, 1'b0, 9'd1, 9'd0);
        hold_off_req = 1'b1;
        random_items(150, 1'b0);
        drain();
        configure(4'd15, 1'b0, 9'd511, 9'd300);
        random_items(40, 1'b0);
        drain();
        configure(4'd1, 1'b1, 9'd511, 9'd257);
        random_items(50, 1'b0);
        drain();
        configure(4'd9, 1'b1, 9'd8, 9'd13);
        random_items(150, 1'b0);
        drain();

        // Random settings, mostly short filters.
        for (int p = 0; p < 8; p++) begin
            fac = $urandom_range(0, 15);
            two = $urandom_range(0, 1);
            t1  = $urandom_range(0, 40);
            t2  = $urandom_range(0, 40);
            configure(4'(fac), 1'(two), 9'(t1), 9'(t2));
            if (p == 7) quiet = 1'b1;
            random_items(85, 1'b0);
            drain();
        end

        if (err_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
